>>> hdl/led_blink_code_indicator_defines.svh
// Assertion macros shared by the blink code indicator.
`ifndef LED_BLINK_CODE_INDICATOR_DEFINES_SVH
`define LED_BLINK_CODE_INDICATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define LBCI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbci: same-cycle check failed");

`define LBCI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbci: next-cycle check failed");

`else

`define LBCI_ASSERT_IMP(label, clk, rst, ante, cons)

`define LBCI_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/lbci_pkg.sv
`default_nettype none

package lbci_pkg;

   localparam int TIME_WIDTH_DEF = 16;
   localparam int CFG_WIDTH      = 16;

   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_SET_MODE = 2'd1;
   localparam logic [1:0] ACT_REPORT   = 2'd2;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;
   localparam logic [1:0] MODE_ERROR = 2'd3;

   localparam logic [1:0] PH_ON    = 2'd0;
   localparam logic [1:0] PH_OFF   = 2'd1;
   localparam logic [1:0] PH_PAUSE = 2'd2;

   localparam logic [3:0] CODE_MIN = 4'd1;
   localparam logic [3:0] CODE_MAX = 4'd9;

   localparam logic [1:0] REG_RUN_PERIOD  = 2'd0;
   localparam logic [1:0] REG_BLINK_TICKS = 2'd1;
   localparam logic [1:0] REG_PAUSE_TICKS = 2'd2;

   localparam logic [CFG_WIDTH-1:0] RUN_PERIOD_RST  = 16'd500;
   localparam logic [CFG_WIDTH-1:0] BLINK_TICKS_RST = 16'd200;
   localparam logic [CFG_WIDTH-1:0] PAUSE_TICKS_RST = 16'd1000;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] new_mode;
      logic [3:0] fault_code;
   } item_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] run_period;
      logic [CFG_WIDTH-1:0] blink_ticks;
      logic [CFG_WIDTH-1:0] pause_ticks;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/led_blink_code_indicator.sv
// Channel   Direction  Ports
// -------   ---------  -----------------------------------------------
// req       in         req_valid/req_ready, action, new_mode, fault_code
// rsp       out        rsp_valid/rsp_ready, led_lit, current_mode
// csr       in         csr_wr_en, csr_index, csr_wdata (write only)
//
// One request is taken every clock cycle unless the response is stalled; each
// gives one response, through the input register, then the state and response
// register.
// Reset is synchronous; it returns the mode to off and the registers to defaults.
// A stalled response holds the state, and the input register fills behind it.
`default_nettype none

module led_blink_code_indicator
   import lbci_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_action,
   input  wire logic [1:0]           req_new_mode,
   input  wire logic [3:0]           req_fault_code,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_led_lit,
   output logic [1:0]                rsp_current_mode,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata
);

   item_type item_ff, item_in;
   logic     item_valid_ff, item_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     advance;
   cfg_type  cfg;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_valid && req_ready) begin
         item_in.action     = req_action;
         item_in.new_mode   = req_new_mode;
         item_in.fault_code = req_fault_code;
         item_valid_in      = 1'b1;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = rsp_valid_ff;

   lbci_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbci_engine #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .item         (item_ff),
      .cfg          (cfg),
      .led_lit      (rsp_led_lit),
      .current_mode (rsp_current_mode)
   );

endmodule

`default_nettype wire

>>> hdl/lbci_csr.sv
`default_nettype none

module lbci_csr
   import lbci_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_RUN_PERIOD:  cfg_in.run_period  = csr_wdata;
            REG_BLINK_TICKS: cfg_in.blink_ticks = csr_wdata;
            REG_PAUSE_TICKS: cfg_in.pause_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_period  <= RUN_PERIOD_RST;
         cfg_ff.blink_ticks <= BLINK_TICKS_RST;
         cfg_ff.pause_ticks <= PAUSE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/lbci_engine.sv
`default_nettype none
`include "led_blink_code_indicator_defines.svh"

module lbci_engine
   import lbci_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output logic          led_lit,
   output logic [1:0]    current_mode
);

   localparam int CMP_W = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

   logic [1:0]            mode_ff, mode_in;
   logic [1:0]            phase_ff, phase_in;
   logic [3:0]            count_ff, count_in;
   logic [3:0]            code_ff, code_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                  led_ff, led_in;

   logic [TIME_WIDTH-1:0] elapsed_sat;
   logic [CMP_W-1:0]      elapsed_cmp;
   logic                  run_due;
   logic                  blink_due;
   logic                  pause_due;
   logic [3:0]            count_next;
   logic                  group_done;
   logic                  code_ok;

   // The count stops at all ones, so an interval above it is never met.
   assign elapsed_sat = (&elapsed_ff) ? elapsed_ff
                                      : elapsed_ff + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
   assign elapsed_cmp = CMP_W'(elapsed_sat);
   assign run_due     = elapsed_cmp >= CMP_W'(cfg.run_period);
   assign blink_due   = elapsed_cmp >= CMP_W'(cfg.blink_ticks);
   assign pause_due   = elapsed_cmp >= CMP_W'(cfg.pause_ticks);
   assign count_next  = count_ff + 4'd1;
   assign group_done  = count_next >= code_ff;
   assign code_ok     = (item.fault_code >= CODE_MIN) && (item.fault_code <= CODE_MAX);

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      code_in    = code_ff;
      elapsed_in = elapsed_ff;
      led_in     = led_ff;
      if (step_en) begin
         unique case (item.action)
            ACT_TICK: begin
               elapsed_in = elapsed_sat;
               unique case (mode_ff)
                  MODE_OFF: led_in = 1'b0;
                  MODE_ON:  led_in = 1'b1;
                  MODE_RUN: begin
                     if (run_due) begin
                        elapsed_in = '0;
                        led_in     = ~led_ff;
                     end
                  end
                  default: begin
                     unique case (phase_ff)
                        PH_ON: begin
                           if (blink_due) begin
                              elapsed_in = '0;
                              led_in     = 1'b0;
                              phase_in   = PH_OFF;
                           end
                        end
                        PH_OFF: begin
                           if (blink_due) begin
                              elapsed_in = '0;
                              count_in   = count_next;
                              if (group_done) begin
                                 phase_in = PH_PAUSE;
                              end else begin
                                 led_in   = 1'b1;
                                 phase_in = PH_ON;
                              end
                           end
                        end
                        PH_PAUSE: begin
                           if (pause_due) begin
                              elapsed_in = '0;
                              count_in   = 4'd0;
                              led_in     = 1'b1;
                              phase_in   = PH_ON;
                           end
                        end
                        default: ;
                     endcase
                  end
               endcase
            end
            ACT_SET_MODE: begin
               mode_in    = item.new_mode;
               elapsed_in = '0;
               if (item.new_mode == MODE_ON) begin
                  led_in = 1'b1;
               end else if (item.new_mode == MODE_OFF) begin
                  led_in = 1'b0;
               end
            end
            ACT_REPORT: begin
               if (code_ok) begin
                  code_in    = item.fault_code;
                  mode_in    = MODE_ERROR;
                  elapsed_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         phase_ff   <= PH_OFF;
         count_ff   <= 4'd0;
         code_ff    <= 4'd0;
         elapsed_ff <= '0;
         led_ff     <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         code_ff    <= code_in;
         elapsed_ff <= elapsed_in;
         led_ff     <= led_in;
      end
   end

   // State only moves when a response is loaded, so it doubles as the response.
   assign led_lit      = led_ff;
   assign current_mode = mode_ff;

   `LBCI_ASSERT_IMP(a_off_dark, clock, reset, mode_ff == MODE_OFF, !led_ff)
   `LBCI_ASSERT_IMP(a_on_lit, clock, reset, mode_ff == MODE_ON, led_ff)
   `LBCI_ASSERT_IMP(a_code_range, clock, reset, 1'b1, code_ff <= CODE_MAX)
   `LBCI_ASSERT_NXT(a_set_clears, clock, reset, step_en && item.action == ACT_SET_MODE, elapsed_ff == '0)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lbci_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         TICK_WIDTH  = TIME_WIDTH_DEF;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         LONG_HOLD   = 60;
   localparam int         ROW_COUNT   = 23;

   typedef struct packed {
      logic       led;
      logic [1:0] mode;
   } lamp_state_type;

   typedef struct packed {
      logic           typed;
      lamp_state_type view;
   } typed_mark_type;

   typedef struct packed {
      logic [1:0] act;
      logic [1:0] nm;
      logic [3:0] fc;
      logic       typed;
      logic       led;
      logic [1:0] mode;
   } lamp_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_action;
   logic [1:0]           req_new_mode;
   logic [3:0]           req_fault_code;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_led_lit;
   logic [1:0]           rsp_current_mode;
   logic                 csr_wr_en;
   logic [1:0]           csr_index;
   logic [CFG_WIDTH-1:0] csr_wdata;

   // Predicted state of the indicator and its timing registers.
   logic [1:0]            lamp_mode;
   logic [1:0]            flash_stage;
   logic [3:0]            flash_tally;
   logic [3:0]            held_code;
   logic [TICK_WIDTH-1:0] tick_count;
   logic                  lamp_on;
   logic [CFG_WIDTH-1:0]  cfg_run_period;
   logic [CFG_WIDTH-1:0]  cfg_blink_ticks;
   logic [CFG_WIDTH-1:0]  cfg_pause_ticks;

   lamp_state_type lamp_expected[$];
   typed_mark_type typed_marks[$];
   int             fail_count;
   int             requests_sent;
   int             cycle_count;
   int             hold_asked;
   int             hold_done;
   bit             idle_on;

   lamp_row_type dir_rows [0:ROW_COUNT-1] = '{
      '{ACT_SET_MODE, MODE_OFF,   4'd15,    1'b1, 1'b0, MODE_OFF},
      '{ACT_TICK,     MODE_ERROR, 4'd15,    1'b1, 1'b0, MODE_OFF},
      '{ACT_SET_MODE, MODE_ON,    4'd0,     1'b1, 1'b1, MODE_ON},
      '{ACT_TICK,     MODE_OFF,   4'd0,     1'b1, 1'b1, MODE_ON},
      '{ACT_SET_MODE, MODE_OFF,   4'd7,     1'b1, 1'b0, MODE_OFF},
      '{ACT_SET_MODE, MODE_RUN,   4'd8,     1'b1, 1'b0, MODE_RUN},
      '{ACT_TICK,     MODE_ON,    4'd3,     1'b0, 1'b0, MODE_OFF},
      '{ACT_REPORT,   MODE_ERROR, 4'd0,     1'b1, 1'b0, MODE_RUN},
      '{ACT_REPORT,   MODE_OFF,   4'd10,    1'b1, 1'b0, MODE_RUN},
      '{ACT_REPORT,   MODE_ON,    4'd15,    1'b1, 1'b0, MODE_RUN},
      '{ACT_UNUSED,   MODE_ERROR, CODE_MAX, 1'b1, 1'b0, MODE_RUN},
      '{ACT_SET_MODE, MODE_ON,    4'd2,     1'b1, 1'b1, MODE_ON},
      '{ACT_SET_MODE, MODE_RUN,   4'd4,     1'b1, 1'b1, MODE_RUN},
      '{ACT_SET_MODE, MODE_ERROR, 4'd11,    1'b1, 1'b1, MODE_ERROR},
      '{ACT_REPORT,   MODE_RUN,   CODE_MIN, 1'b1, 1'b1, MODE_ERROR},
      '{ACT_TICK,     MODE_ERROR, 4'd14,    1'b0, 1'b0, MODE_OFF},
      '{ACT_REPORT,   MODE_OFF,   CODE_MAX, 1'b0, 1'b0, MODE_OFF},
      '{ACT_SET_MODE, MODE_OFF,   4'd1,     1'b1, 1'b0, MODE_OFF},
      '{ACT_REPORT,   MODE_ON,    4'd5,     1'b1, 1'b0, MODE_ERROR},
      '{ACT_TICK,     MODE_RUN,   4'd13,    1'b0, 1'b0, MODE_OFF},
      '{ACT_SET_MODE, MODE_ERROR, 4'd12,    1'b0, 1'b0, MODE_OFF},
      '{ACT_TICK,     MODE_RUN,   4'd6,     1'b0, 1'b0, MODE_OFF},
      '{ACT_SET_MODE, MODE_RUN,   4'd3,     1'b0, 1'b0, MODE_OFF}
   };

   led_blink_code_indicator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_new_mode     (req_new_mode),
      .req_fault_code   (req_fault_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_lit      (rsp_led_lit),
      .rsp_current_mode (rsp_current_mode),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic enter_mode(input logic [1:0] m);
      lamp_mode  = m;
      tick_count = '0;
      if (m == MODE_ON) begin
         lamp_on = 1'b1;
      end else if (m == MODE_OFF) begin
         lamp_on = 1'b0;
      end
   endtask

   task automatic step_indicator(input logic [1:0] act, input logic [1:0] nm,
                                 input logic [3:0] fc);
      case (act)
         ACT_TICK: begin
            if (tick_count != '1) begin
               tick_count = tick_count + 1'b1;
            end
            case (lamp_mode)
               MODE_OFF: lamp_on = 1'b0;
               MODE_ON:  lamp_on = 1'b1;
               MODE_RUN: begin
                  if (tick_count >= cfg_run_period) begin
                     tick_count = '0;
                     lamp_on    = ~lamp_on;
                  end
               end
               default: begin
                  case (flash_stage)
                     PH_ON: begin
                        if (tick_count >= cfg_blink_ticks) begin
                           tick_count  = '0;
                           lamp_on     = 1'b0;
                           flash_stage = PH_OFF;
                        end
                     end
                     PH_OFF: begin
                        if (tick_count >= cfg_blink_ticks) begin
                           tick_count  = '0;
                           flash_tally = flash_tally + 1'b1;
                           if (flash_tally >= held_code) begin
                              flash_stage = PH_PAUSE;
                           end else begin
                              lamp_on     = 1'b1;
                              flash_stage = PH_ON;
                           end
                        end
                     end
                     PH_PAUSE: begin
                        if (tick_count >= cfg_pause_ticks) begin
                           tick_count  = '0;
                           flash_tally = '0;
                           lamp_on     = 1'b1;
                           flash_stage = PH_ON;
                        end
                     end
                     default: ;
                  endcase
               end
            endcase
         end
         ACT_SET_MODE: enter_mode(nm);
         ACT_REPORT: begin
            if (fc >= CODE_MIN && fc <= CODE_MAX) begin
               held_code = fc;
               enter_mode(MODE_ERROR);
            end
         end
         default: ;
      endcase
   endtask

   // Predict on every accepted request first, so that a response in the same
   // cycle always finds its expectation already queued.
   always @(posedge clock) begin
      typed_mark_type note;
      lamp_state_type want;
      lamp_state_type guess;
      if (!reset) begin
         if (req_valid && req_ready) begin
            step_indicator(req_action, req_new_mode, req_fault_code);
            guess.led  = lamp_on;
            guess.mode = lamp_mode;
            note.typed = 1'b0;
            if (typed_marks.size() != 0) begin
               note = typed_marks.pop_front();
            end
            lamp_expected.push_back(note.typed ? note.view : guess);
         end
         if (rsp_valid && rsp_ready) begin
            if (lamp_expected.size() == 0) begin
               $display("%0t: response with none outstanding: led_lit %0b current_mode %0d",
                        $time, rsp_led_lit, rsp_current_mode);
               fail_count++;
            end else begin
               want = lamp_expected.pop_front();
               if (rsp_led_lit !== want.led) begin
                  $display("%0t: led_lit expected %0b actual %0b",
                           $time, want.led, rsp_led_lit);
                  fail_count++;
               end
               if (rsp_current_mode !== want.mode) begin
                  $display("%0t: current_mode expected %0d actual %0d",
                           $time, want.mode, rsp_current_mode);
                  fail_count++;
               end
            end
         end
      end
   end

   // Response side: random stall bursts, and a long hold-off when asked.
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_done++;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_request(input logic [1:0] act, input logic [1:0] nm,
                               input logic [3:0] fc, input logic typed,
                               input lamp_state_type view);
      typed_mark_type note;
      int             gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      note.typed = typed;
      note.view  = view;
      typed_marks.push_back(note);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_new_mode   <= nm;
      req_fault_code <= fc;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_request(ACT_TICK, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0, '0);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (lamp_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_lamp_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_RUN_PERIOD:  cfg_run_period  = val;
         REG_BLINK_TICKS: cfg_blink_ticks = val;
         REG_PAUSE_TICKS: cfg_pause_ticks = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_timing(input int rp, input int bt, input int pt);
      write_lamp_reg(REG_RUN_PERIOD, CFG_WIDTH'(rp));
      write_lamp_reg(REG_BLINK_TICKS, CFG_WIDTH'(bt));
      write_lamp_reg(REG_PAUSE_TICKS, CFG_WIDTH'(pt));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      lamp_state_type view;
      int             stage;
      int             stage_start;
      int             n;
      bit             hold_given;
      bit             drain_given;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_TICK;
      req_new_mode   = MODE_OFF;
      req_fault_code = 4'd0;
      csr_wr_en      = 1'b0;
      csr_index      = REG_RUN_PERIOD;
      csr_wdata      = '0;
      fail_count     = 0;
      requests_sent  = 0;
      cycle_count    = 0;
      hold_asked     = 0;
      hold_done      = 0;
      idle_on        = 1'b1;
      hold_given     = 1'b0;
      drain_given    = 1'b0;

      lamp_mode       = MODE_OFF;
      flash_stage     = PH_OFF;
      flash_tally     = '0;
      held_code       = '0;
      tick_count      = '0;
      lamp_on         = 1'b0;
      cfg_run_period  = RUN_PERIOD_RST;
      cfg_blink_ticks = BLINK_TICKS_RST;
      cfg_pause_ticks = PAUSE_TICKS_RST;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: with a code of two stored, the first dark phase ends on
      // the two hundredth tick and the next flash lights.
      send_request(ACT_REPORT, MODE_OFF, 4'd2, 1'b0, '0);
      repeat (200) send_tick();

      for (int r = 0; r < ROW_COUNT; r++) begin
         view.led  = dir_rows[r].led;
         view.mode = dir_rows[r].mode;
         send_request(dir_rows[r].act, dir_rows[r].nm, dir_rows[r].fc, dir_rows[r].typed, view);
      end

      for (stage = 0; stage < 8; stage++) begin
         wait_for_responses();
         case (stage)
            0: program_timing(1, 1, 1);
            1: program_timing(2, 3, 5);
            3: program_timing($urandom_range(1, 12), $urandom_range(1, 12),
                              $urandom_range(1, 12));
            5: program_timing($urandom_range(1, 40), $urandom_range(1, 4),
                              $urandom_range(1, 16));
            6: program_timing(65535, 65535, 65535);
            default: program_timing($urandom_range(1, 8), $urandom_range(1, 8),
                                    $urandom_range(1, 8));
         endcase
         idle_on = (stage != 3 && stage < 6);

         if (stage == 6) begin
            // Widest intervals: nothing falls due within the ticks sent.
            send_request(ACT_SET_MODE, MODE_RUN, 4'd0, 1'b0, '0);
            repeat (40) send_tick();
            send_request(ACT_REPORT, MODE_ON, 4'($urandom_range(CODE_MIN, CODE_MAX)),
                         1'b0, '0);
            repeat (40) send_tick();
         end else begin
            stage_start = requests_sent;
            while (requests_sent - stage_start < 70) begin
               if (stage == 2 && !hold_given && requests_sent - stage_start >= 40) begin
                  hold_asked++;
                  hold_given = 1'b1;
               end
               if (stage == 4 && !drain_given && requests_sent - stage_start >= 50) begin
                  wait_for_responses();
                  drain_given = 1'b1;
               end
               if ($urandom_range(0, 9) < 6) begin
                  // A valid report or mode change, then time running on.
                  if ($urandom_range(0, 1) == 1) begin
                     send_request(ACT_REPORT, 2'($urandom_range(0, 3)),
                                  4'($urandom_range(CODE_MIN, CODE_MAX)), 1'b0, '0);
                  end else begin
                     send_request(ACT_SET_MODE, 2'($urandom_range(0, 3)),
                                  4'($urandom_range(0, 15)), 1'b0, '0);
                  end
                  n = $urandom_range(4, 50);
                  repeat (n) send_tick();
               end else begin
                  n = $urandom_range(1, 4);
                  repeat (n) begin
                     send_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                  4'($urandom_range(0, 15)), 1'b0, '0);
                  end
               end
            end
         end
      end

      wait_for_responses();
      repeat (6) @(negedge clock);
      if (fail_count == 0 && lamp_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
